### design/itoaf_pkg.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Format mode codes, character constants and field widths shared by the
// formatter and its checker.
// ----------------------------------------------------------------------------
package itoaf_pkg;

    localparam int NUMBER_W   = 32;
    localparam int HEXCNT_W   = 3;
    localparam int MODE_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int IN_DATA_W  = 40;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    localparam logic [MODE_W-1:0] MODE_HEX   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UDEC16 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UDEC32 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SDEC16 = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [HEXCNT_W-1:0] HEX_MAX_DIGITS = 3'd4;

    // ASCII code of one digit, 0-9 then upper-case A-F
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_UPPER_A + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

### design/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Prints one number per request as ASCII characters, hex or decimal.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one request: tdata = number[31:0], hex_digits[34:32];
//   tuser = mode (0 hex, 1 unsigned 16-bit, 2 unsigned 32-bit, 3 signed
//   16-bit decimal). Master side gives one character per beat in tdata,
//   most significant first, with tlast on the final character.
//   One request is worked on at a time; tready is high only while idle.
//   Decimal conversion runs a bit-serial shift-and-add-3 loop, one input bit
//   per cycle, over 16 input bits in the 16-bit modes and 32 in the 32-bit
//   mode. Then leading digit positions (of ten for decimal, four for hex)
//   are dropped one per cycle: zeros in decimal mode or with a hex count of
//   zero, else positions beyond the hex count, keeping at least one digit.
//   The block then moves on to output, and characters leave one per cycle
//   while the receiver takes them.
//   The character register is a one-deep output stage: while the receiver
//   stalls the block holds the character and waits before loading the next
//   one; the next request is taken while the final character still waits.
//   Synchronous active-low reset returns the block to idle and drops any
//   pending character.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // number [31:0], hex_digits [34:32], zero fill [39:35]
    input  logic [itoaf_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // mode [1:0]
    input  logic [itoaf_pkg::MODE_W-1:0]        i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // character [7:0]
    output logic [itoaf_pkg::CHAR_W-1:0]        o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);
    import itoaf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    t_state                  r_state;
    logic [NUMBER_W-1:0]     r_bin;
    logic [BCD_W-1:0]        r_bcd;
    logic [5:0]              r_cnt;
    logic [3:0]              r_rem;
    logic [HEXCNT_W-1:0]     r_keep;
    logic                    r_auto;
    logic                    r_m_tvalid;
    logic [CHAR_W-1:0]       r_char;
    logic                    r_last;

    logic [BCD_W-1:0]        n_bcd;
    logic [15:0]             w_low;
    logic [15:0]             w_mag;
    logic [HEXCNT_W-1:0]     w_hexcnt;
    logic                    w_in_acc;
    logic                    w_out_free;
    logic                    w_load;
    logic [3:0]              w_top;
    logic                    w_skip;
    logic [NUMBER_W-1:0]     w_in_number;
    logic [HEXCNT_W-1:0]     w_in_hexcnt;

    assign w_in_number = i_s_axis_tdata[NUMBER_W-1:0];
    assign w_in_hexcnt = i_s_axis_tdata[NUMBER_W +: HEXCNT_W];
    assign w_low       = w_in_number[15:0];
    // two's complement magnitude; 0x8000 maps onto itself
    assign w_mag       = w_low[15] ? (16'd0 - w_low) : w_low;
    assign w_hexcnt    = (w_in_hexcnt > HEX_MAX_DIGITS) ? HEX_MAX_DIGITS : w_in_hexcnt;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_m_tvalid || i_m_axis_tready;
    assign w_load          = ((r_state == ST_SIGN) || (r_state == ST_EMIT)) && w_out_free;
    assign w_top           = r_bcd[BCD_W-1 -: 4];

    // drop a leading position: forced by the hex count, or a zero in auto width
    assign w_skip = (r_rem > 4'd1) &&
                    ((r_auto && (w_top == 4'd0)) ||
                     (!r_auto && (r_rem > {1'b0, r_keep})));

    // add 3 to every BCD digit of 5 or more, then shift in the next bit
    always_comb begin
        logic [BCD_W-1:0] adj;
        adj = r_bcd;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end
        end
        n_bcd = {adj[BCD_W-2:0], r_bin[NUMBER_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            // load a new character, or drop the taken one
            if (w_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_keep <= w_hexcnt;
                        unique case (i_s_axis_tuser)
                            MODE_HEX: begin
                                r_bcd   <= {w_low, {(BCD_W-16){1'b0}}};
                                r_rem   <= 4'd4;
                                r_auto  <= (w_hexcnt == '0);
                                r_state <= ST_SKIP;
                            end
                            MODE_UDEC16: begin
                                r_bcd   <= '0;
                                r_rem   <= 4'(BCD_DIGITS);
                                r_auto  <= 1'b1;
                                r_bin   <= {w_low, 16'd0};
                                r_cnt   <= 6'd16;
                                r_state <= ST_CONV;
                            end
                            MODE_UDEC32: begin
                                r_bcd   <= '0;
                                r_rem   <= 4'(BCD_DIGITS);
                                r_auto  <= 1'b1;
                                r_bin   <= w_in_number;
                                r_cnt   <= 6'd32;
                                r_state <= ST_CONV;
                            end
                            MODE_SDEC16: begin
                                r_bcd   <= '0;
                                r_rem   <= 4'(BCD_DIGITS);
                                r_auto  <= 1'b1;
                                r_bin   <= {w_mag, 16'd0};
                                r_cnt   <= 6'd16;
                                r_state <= w_low[15] ? ST_SIGN : ST_CONV;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SIGN: begin
                    if (w_out_free) begin
                        r_char     <= CHAR_MINUS;
                        r_last     <= 1'b0;
                        r_state    <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_bcd <= n_bcd;
                    r_bin <= {r_bin[NUMBER_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    if (w_skip) begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_rem <= r_rem - 4'd1;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_char     <= digit_char(w_top);
                        r_last     <= (r_rem == 4'd1);
                        r_bcd      <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_rem      <= r_rem - 4'd1;
                        if (r_rem == 4'd1) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_char;
    assign o_m_axis_tlast  = r_last;

endmodule

### design/itoaf_checker.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter checker
// Port-level properties of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module itoaf_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    input  logic                                o_s_axis_tready,
    input  logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [itoaf_pkg::CHAR_W-1:0]        o_m_axis_tdata,
    input  logic                                o_m_axis_tlast
);
    import itoaf_pkg::*;

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled character changed");

    // one request at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while busy");

    // only digits, upper-case hex letters and a non-final minus sign leave
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata >= CHAR_ZERO && o_m_axis_tdata <= CHAR_NINE) ||
            (o_m_axis_tdata >= CHAR_UPPER_A && o_m_axis_tdata <= CHAR_UPPER_F) ||
            (o_m_axis_tdata == CHAR_MINUS && !o_m_axis_tlast))
        else $error("illegal character");

    // reset leaves the block idle with nothing pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind integer_to_ascii_formatter itoaf_checker u_itoaf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
